// ===== rtl/arce_pkg.sv =====
// Shared types, constants and helper functions for the adaptive Rice codeword encoder.
// Standalone package; the encoder modules import it.
`default_nettype none

package arce_pkg;

   localparam int unsigned SAMPLE_W  = 32;
   localparam int unsigned AVG_W     = 27;
   localparam int unsigned K_W       = 5;
   localparam int unsigned LIMIT_W   = 4;
   localparam int unsigned WEIGHT_W  = 6;
   localparam int unsigned ZRUN_W    = 6;
   localparam int unsigned SLEN_W    = 5;
   localparam int unsigned SBITS_W   = 31;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 6;
   // average update divides by 32
   localparam int unsigned AVG_SHIFT = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_QUOTIENT_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AVERAGE_WEIGHT = 1'd1;

   // register reset values
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 4'd7;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 6'd23;

   typedef struct packed {
      logic [ZRUN_W-1:0]  zero_run;
      logic [SLEN_W-1:0]  suffix_len;
      logic [SBITS_W-1:0] suffix_bits;
      logic               escaped;
   } codeword_type;

   // Position of the highest set bit; 0 for a zero word. Five-step binary search.
   function automatic logic [4:0] msb_pos(input logic [31:0] v);
      logic [31:0] t;
      logic [4:0]  p;
      t = v;
      p = '0;
      if (t[31:16] != 16'd0) begin
         p[4] = 1'b1;
         t    = t >> 16;
      end
      if (t[15:8] != 8'd0) begin
         p[3] = 1'b1;
         t    = t >> 8;
      end
      if (t[7:4] != 4'd0) begin
         p[2] = 1'b1;
         t    = t >> 4;
      end
      if (t[3:2] != 2'd0) begin
         p[1] = 1'b1;
         t    = t >> 2;
      end
      if (t[1] != 1'b0) begin
         p[0] = 1'b1;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/arce_avg_track.sv =====
// Running-average register and Rice parameter derivation.
// Depends on arce_pkg.
`default_nettype none

module arce_avg_track (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           block_start,
   input  wire logic [arce_pkg::SAMPLE_W-1:0]  sample,
   input  wire logic [arce_pkg::WEIGHT_W-1:0]  weight,
   output logic      [arce_pkg::K_W-1:0]       rice_k
);
   import arce_pkg::*;

   logic [AVG_W-1:0]    avg_ff;
   logic [AVG_W-1:0]    avg_in;
   logic [AVG_W-1:0]    avg_eff;
   logic [AVG_W:0]      avg_plus1;
   logic [SAMPLE_W-1:0] diff;
   logic [SAMPLE_W-1:0] prod;
   logic [SAMPLE_W-1:0] sum;

   assign avg_eff   = block_start ? '0 : avg_ff;
   assign avg_plus1 = {1'b0, avg_eff} + {{AVG_W{1'b0}}, 1'b1};
   assign rice_k    = msb_pos({{(SAMPLE_W-AVG_W-1){1'b0}}, avg_plus1});

   // w*avg + (32-w)*x == 32*x + w*(avg-x)  (mod 2^32)
   assign diff   = {{(SAMPLE_W-AVG_W){1'b0}}, avg_eff} - sample;
   assign prod   = SAMPLE_W'(diff * {{(SAMPLE_W-WEIGHT_W){1'b0}}, weight});
   assign sum    = {sample[SAMPLE_W-AVG_SHIFT-1:0], {AVG_SHIFT{1'b0}}} + prod;
   assign avg_in = sum[SAMPLE_W-1:AVG_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else if (advance) begin
         avg_ff <= avg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/arce_codeword.sv =====
// Combinational Rice / escape codeword former.
// Depends on arce_pkg.
`default_nettype none

module arce_codeword (
   input  wire logic [arce_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [arce_pkg::K_W-1:0]      rice_k,
   input  wire logic [arce_pkg::LIMIT_W-1:0]  limit,
   output arce_pkg::codeword_type             word
);
   import arce_pkg::*;

   logic [SAMPLE_W-1:0] quot;
   logic [SAMPLE_W-1:0] low_mask;
   logic [SAMPLE_W-1:0] low_bits;
   logic                plain;
   logic [SAMPLE_W-1:0] limit_sh;
   logic [SAMPLE_W-1:0] rem;
   logic [4:0]          top;
   logic [SAMPLE_W-1:0] rem_clr;

   assign quot     = sample >> rice_k;
   assign low_mask = (SAMPLE_W'(1) << rice_k) - SAMPLE_W'(1);
   assign low_bits = sample & low_mask;
   assign plain    = (quot[SAMPLE_W-1:LIMIT_W] == '0) && (quot[LIMIT_W-1:0] <= limit);

   // escape: (q-limit)<<k | low == x - (limit<<k); drop its leading one
   assign limit_sh = {{(SAMPLE_W-LIMIT_W){1'b0}}, limit} << rice_k;
   assign rem      = sample - limit_sh;
   assign top      = msb_pos(rem);
   assign rem_clr  = rem & ~(SAMPLE_W'(1) << top);

   always_comb begin
      if (plain) begin
         word.zero_run    = {{(ZRUN_W-LIMIT_W){1'b0}}, quot[LIMIT_W-1:0]};
         word.suffix_len  = rice_k;
         word.suffix_bits = low_bits[SBITS_W-1:0];
         word.escaped     = 1'b0;
      end else begin
         word.zero_run    = {{(ZRUN_W-LIMIT_W){1'b0}}, limit} + {1'b0, top} + ZRUN_W'(1)
                            - {1'b0, rice_k};
         word.suffix_len  = top;
         word.suffix_bits = rem_clr[SBITS_W-1:0];
         word.escaped     = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/adaptive_rice_codeword_encoder.sv =====
// Top level of the adaptive Rice codeword encoder: handshakes, CSRs, pipeline registers.
// Depends on arce_pkg, arce_avg_track and arce_codeword.
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  sample_value[31:0], block_start
// rsp_      out        rsp_valid/rsp_ready  zero_run[5:0], suffix_len[4:0],
//                                           suffix_bits[30:0], escaped
// csr_      in         csr_write_en         csr_index[0], csr_wdata[5:0]
//
// An accepted item passes the input register, then the output register, before
// rsp_valid rises; one item per cycle sustained while rsp_ready does not stall.
// The running-average feedback (one 6x32 multiply and an add) closes through the
// average register, which sets the rate.
// Reset (synchronous) empties both stages, clears the average, loads defaults.
// A stalled rsp holds its output register; the input register still fills, then
// req_ready drops until the output side moves.

module adaptive_rice_codeword_encoder (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input item channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [arce_pkg::SAMPLE_W-1:0]   req_sample_value,
   input  wire logic                            req_block_start,
   // result item channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [arce_pkg::ZRUN_W-1:0]     rsp_zero_run,
   output logic      [arce_pkg::SLEN_W-1:0]     rsp_suffix_len,
   output logic      [arce_pkg::SBITS_W-1:0]    rsp_suffix_bits,
   output logic                                 rsp_escaped,
   // register write port
   input  wire logic                            csr_write_en,
   input  wire logic [arce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [arce_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import arce_pkg::*;

   // configuration registers
   logic [LIMIT_W-1:0]  limit_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   // input stage
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                in_start_ff;

   // output stage
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   codeword_type        rsp_word_ff;

   logic                req_fire;
   logic                out_free;
   logic                advance;
   logic [K_W-1:0]      rice_k;
   codeword_type        word;

   // pipeline control: an item moves to the output register when that
   // register is empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_sample_ff <= req_sample_value;
         in_start_ff  <= req_block_start;
      end
      if (advance) begin
         rsp_word_ff <= word;
      end
   end

   // CSR writes; data bits above a register's width are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= LIMIT_RESET;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_QUOTIENT_LIMIT: limit_ff  <= csr_wdata[LIMIT_W-1:0];
            REG_AVERAGE_WEIGHT: weight_ff <= csr_wdata[WEIGHT_W-1:0];
         endcase
      end
   end

   // average tracks items in acceptance order; it updates as the item leaves
   // the input stage, so k reflects every earlier item since the last block start
   arce_avg_track u_avg_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .block_start (in_start_ff),
      .sample      (in_sample_ff),
      .weight      (weight_ff),
      .rice_k      (rice_k)
   );

   arce_codeword u_codeword (
      .sample (in_sample_ff),
      .rice_k (rice_k),
      .limit  (limit_ff),
      .word   (word)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_zero_run    = rsp_word_ff.zero_run;
   assign rsp_suffix_len  = rsp_word_ff.suffix_len;
   assign rsp_suffix_bits = rsp_word_ff.suffix_bits;
   assign rsp_escaped     = rsp_word_ff.escaped;

endmodule

`default_nettype wire

// ===== dv/tb_adaptive_rice_codeword_encoder.sv =====
// Self-checking testbench for adaptive_rice_codeword_encoder: directed and random items
// with a cycle-free codeword predictor and an in-order scoreboard. Depends on arce_pkg.
`timescale 1ns / 100ps

module tb_adaptive_rice_codeword_encoder;
   import arce_pkg::*;

   // ---------------------------------------------------------------------------------
   // Clock, reset and DUT-facing signals. Every input starts at a known value.
   // ---------------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [SAMPLE_W-1:0]  req_sample_value = '0;
   logic                 req_block_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ZRUN_W-1:0]    rsp_zero_run;
   logic [SLEN_W-1:0]    rsp_suffix_len;
   logic [SBITS_W-1:0]   rsp_suffix_bits;
   logic                 rsp_escaped;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   adaptive_rice_codeword_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_block_start  (req_block_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_zero_run     (rsp_zero_run),
      .rsp_suffix_len   (rsp_suffix_len),
      .rsp_suffix_bits  (rsp_suffix_bits),
      .rsp_escaped      (rsp_escaped),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // Predictor state: our own copy of the registers and the running average.
   // ---------------------------------------------------------------------------------
   logic [LIMIT_W-1:0]  trk_limit;
   logic [WEIGHT_W-1:0] trk_weight;
   logic [AVG_W-1:0]    trk_average;
   codeword_type        expected_codewords[$];
   int unsigned         mismatch_count = 0;

   // idle odds in percent, changed per test phase
   int unsigned         sender_idle_pct = 0;
   int unsigned         rsp_idle_pct    = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the handshake locks up.
   initial begin
      #(5_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Result-side back-pressure, redrawn every cycle.
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------------
   // Codeword predictor
   // ---------------------------------------------------------------------------------
   function automatic int unsigned bit_len(input logic [31:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < 32; i++)
         if (v[i]) n = i + 1;
      return n;
   endfunction

   // Codes one sample and advances the tracked average.
   function automatic codeword_type predict_codeword(input logic [31:0] x, input logic bs);
      logic [31:0]  avg32, q, low_bits, qe, wt32, mix;
      logic [63:0]  sfx;
      int unsigned  k, b;
      codeword_type cw;
      if (bs) trk_average = '0;
      avg32    = {5'd0, trk_average};
      k        = bit_len(avg32 + 32'd1) - 1;     // floor(log2(avg+1)), 0..27
      q        = x >> k;
      low_bits = x & ((32'd1 << k) - 32'd1);
      if (q <= {28'd0, trk_limit}) begin
         cw.zero_run    = ZRUN_W'(q);
         cw.suffix_len  = SLEN_W'(k);
         cw.suffix_bits = SBITS_W'(low_bits);
         cw.escaped     = 1'b0;
      end else begin
         // escape: extra zeros give the bit length of the excess, the leading one is implied
         qe  = q - {28'd0, trk_limit};
         b   = bit_len(qe);
         sfx = ({32'd0, qe} & ((64'd1 << (b - 1)) - 64'd1)) << k;
         sfx = sfx | {32'd0, low_bits};
         cw.zero_run    = ZRUN_W'(trk_limit + b);
         cw.suffix_len  = SLEN_W'(b - 1 + k);
         cw.suffix_bits = SBITS_W'(sfx);
         cw.escaped     = 1'b1;
      end
      // 32-bit wrapping products and sum; weights above 32 wrap the complement
      wt32        = {26'd0, trk_weight};
      mix         = wt32 * avg32 + (32'd32 - wt32) * x;
      trk_average = mix[31:AVG_SHIFT];
      return cw;
   endfunction

   // ---------------------------------------------------------------------------------
   // Port monitor: checks results, predicts accepted items, tracks register writes.
   // Results are checked before the same edge's item is queued.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      codeword_type exp_cw;
      if (reset) begin
         trk_limit   = LIMIT_RESET;
         trk_weight  = WEIGHT_RESET;
         trk_average = '0;
         expected_codewords.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codewords.size() == 0) begin
               $error("unexpected result item: zero_run %0d suffix_len %0d", rsp_zero_run,
                      rsp_suffix_len);
               mismatch_count++;
            end else begin
               exp_cw = expected_codewords.pop_front();
               if (rsp_zero_run !== exp_cw.zero_run) begin
                  $error("zero_run: expected %0d, actual %0d", exp_cw.zero_run, rsp_zero_run);
                  mismatch_count++;
               end
               if (rsp_suffix_len !== exp_cw.suffix_len) begin
                  $error("suffix_len: expected %0d, actual %0d", exp_cw.suffix_len,
                         rsp_suffix_len);
                  mismatch_count++;
               end
               if (rsp_suffix_bits !== exp_cw.suffix_bits) begin
                  $error("suffix_bits: expected 0x%08h, actual 0x%08h", exp_cw.suffix_bits,
                         rsp_suffix_bits);
                  mismatch_count++;
               end
               if (rsp_escaped !== exp_cw.escaped) begin
                  $error("escaped: expected %0b, actual %0b", exp_cw.escaped, rsp_escaped);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_codewords.push_back(predict_codeword(req_sample_value, req_block_start));
         if (csr_write_en) begin
            case (csr_index)
               REG_QUOTIENT_LIMIT: trk_limit  = csr_wdata[LIMIT_W-1:0];
               REG_AVERAGE_WEIGHT: trk_weight = csr_wdata[WEIGHT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------

   // Sends one item; returns right after the edge that accepts it, valid still high.
   task automatic send_sample(input logic [31:0] x, input logic bs);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid        <= 1'b0;
         req_sample_value <= $urandom;     // junk while idle
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= x;
      req_block_start  <= bs;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drops valid and waits until every expected result is back, then idles on
   // so both pipeline stages are surely empty.
   task automatic settle();
      int unsigned guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_codewords.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_codewords.size() != 0) begin
         $error("%0d expected results never arrived", expected_codewords.size());
         mismatch_count++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Random limit (upper write bits random, must be dropped) and a weight that
   // favors the extremes, including the wrapping range above 32.
   task automatic random_settings();
      logic [CSR_DAT_W-1:0] wt;
      case ($urandom_range(5))
         0:       wt = 6'd0;
         1:       wt = 6'd32;
         2:       wt = 6'd63;
         default: wt = CSR_DAT_W'($urandom_range(0, 63));
      endcase
      write_reg(REG_QUOTIENT_LIMIT, CSR_DAT_W'($urandom_range(0, 63)));
      write_reg(REG_AVERAGE_WEIGHT, wt);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Reset register values: plain at the limit, escape just past it, widest escape, deepest k.
   task automatic test_reset_defaults();
      send_sample(32'h0000_0000, 1'b1);
      send_sample(32'h0000_0007, 1'b1);    // q equals limit: still plain
      send_sample(32'h0000_0008, 1'b1);    // one past: escape with one-bit excess
      send_sample(32'hFFFF_FFFF, 1'b1);    // k = 0, 32-bit excess
      send_sample(32'hFFFF_FFFF, 1'b0);    // wrapped update drives k to 27
      send_sample(32'h5555_5555, 1'b0);
      send_sample(32'hAAAA_AAAA, 1'b0);
      settle();
   endtask

   // Limit 0 and weight 0: the average follows the sample, so k swings 0 <-> 27.
   task automatic test_escape_deep_parameter();
      write_reg(REG_QUOTIENT_LIMIT, 6'h30);   // upper bits dropped -> limit 0
      write_reg(REG_AVERAGE_WEIGHT, 6'd0);
      send_sample(32'h07FF_FFFF, 1'b1);
      send_sample(32'h0000_0000, 1'b0);       // k = 27, plain, empty quotient
      send_sample(32'h07FF_FFFF, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);       // longest suffix, all ones
      settle();
   endtask

   // Weight 32 freezes the average; above 32 the complement wraps.
   task automatic test_weight_extremes();
      write_reg(REG_QUOTIENT_LIMIT, 6'h3F);   // limit 15
      write_reg(REG_AVERAGE_WEIGHT, 6'd32);
      send_sample(32'h1234_5678, 1'b1);
      send_sample(32'h0000_000F, 1'b0);
      send_sample(32'h0000_0010, 1'b0);
      settle();
      write_reg(REG_AVERAGE_WEIGHT, 6'd63);
      send_sample(32'hDEAD_BEEF, 1'b1);
      send_sample(32'h0000_0100, 1'b0);
      send_sample(32'hFFFF_FFFF, 1'b0);
      send_sample(32'h0000_0001, 1'b0);
      settle();
      write_reg(REG_QUOTIENT_LIMIT, 6'h05);
      write_reg(REG_AVERAGE_WEIGHT, 6'd33);
      send_sample(32'h8000_0000, 1'b1);
      send_sample(32'h0000_FFFF, 1'b0);
      send_sample(32'h0000_0003, 1'b0);
      settle();
   endtask

   // Runs of samples around one magnitude so the average settles and k follows,
   // with outliers that force escapes; settings change every 60 items or so.
   task automatic test_random_stream(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_items);
      int unsigned sent, next_cfg, run_len, mag;
      logic [31:0] x;
      logic        bs;
      sender_idle_pct = snd_pct;
      rsp_idle_pct    = rcv_pct;
      sent     = 0;
      next_cfg = 0;
      while (sent < n_items) begin
         if (sent >= next_cfg) begin
            settle();
            random_settings();
            next_cfg = sent + 60;
         end
         mag     = $urandom_range(0, 26);
         run_len = $urandom_range(4, 20);
         bs      = ($urandom_range(1) == 0);
         for (int j = 0; j < run_len; j++) begin
            case ($urandom_range(7))
               0:       x = $urandom;
               1:       x = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
               2:       x = $urandom >> $urandom_range(0, 31);
               default: x = $urandom_range(0, 255) << mag;
            endcase
            send_sample(x, bs);
            bs = ($urandom_range(31) == 0);
            sent++;
         end
      end
      settle();
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------
   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      sender_idle_pct = 29;
      rsp_idle_pct    = 47;
      test_reset_defaults();
      test_escape_deep_parameter();
      test_weight_extremes();

      test_random_stream(29, 47, 160);
      test_random_stream(47, 29, 160);
      test_random_stream(0, 0, 160);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_codewords.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
